### rtl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// Spring force package
// Shared widths, register indexes and reset values for the spring force block.
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int DEF_COORD_WIDTH = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REST_LENGTH = 2'd0,
    REG_STIFFNESS   = 2'd1,
    REG_FORCE_LIMIT = 2'd2
  } cfg_reg_t;

  localparam int REST_W  = 16;
  localparam int K_W     = 24;
  localparam int LIMIT_W = 24;
  localparam int OUT_W   = 24;
  localparam int QUOT_W  = 24;

  localparam logic [REST_W-1:0]  REST_RESET  = 16'd7680;
  localparam logic [K_W-1:0]     K_RESET     = 24'd58982;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd6554;

  localparam longint OUT_MAX  = 64'sd8388607;
  localparam longint OUT_MIN  = -64'sd8388608;
  localparam longint DIFF_CAP = 64'sd2147483648;

  localparam int MAG_SHIFT = 8;

endpackage

### rtl/spring_force_limited.sv
// ----------------------------------------------------------------------------
// Spring force with limit
// Hooke spring between two 2D points: length, stretch and clamped force on A.
// ----------------------------------------------------------------------------
// The block takes one point pair per clock and returns one result per clock
// through a fully pipelined datapath while the output is not stalled. Its
// stages are the difference, square and sum registers, a one-bit-per-stage
// square root, the stretch, force magnitude and numerator stages, a
// one-bit-per-stage divider for both components, and the output register.
// A stalled output freezes the whole pipeline. Configuration writes are taken
// every cycle and should only occur while no transaction is in flight.
module spring_force_limited
  import sfl_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       force_x,
  output logic signed [OUT_W-1:0]       force_y,
  output logic signed [OUT_W-1:0]       stretch,
  output logic                          coincident,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW;
  localparam int SQW  = 2 * CW + 1;
  localparam int RW   = CW + 1;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;
  localparam int STW  = RW + 1;
  localparam int KPW  = K_W + RW;
  localparam int RNW  = KPW - MAG_SHIFT;
  localparam int MPW  = LIMIT_W + MW;
  localparam int NW   = MPW + 2;
  localparam int DW   = RW + 1;

  // Configuration registers
  logic [REST_W-1:0]  rest_length;
  logic [K_W-1:0]     stiffness;
  logic [LIMIT_W-1:0] force_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length <= REST_RESET;
      stiffness   <= K_RESET;
      force_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_REST_LENGTH: rest_length <= cfg_data[REST_W-1:0];
        REG_STIFFNESS:   stiffness   <= cfg_data[K_W-1:0];
        REG_FORCE_LIMIT: force_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: differences and capped magnitudes
  logic          v1, negx1, negy1;
  logic [MW-1:0] adx1, ady1;
  logic signed [CW:0] dx_c, dy_c;
  logic [CW:0]   absx_c, absy_c;
  logic [63:0]   ax64_c, ay64_c;
  logic [MW-1:0] adx_c, ady_c;

  always_comb begin
    dx_c   = {a_x[CW-1], a_x} - {b_x[CW-1], b_x};
    dy_c   = {a_y[CW-1], a_y} - {b_y[CW-1], b_y};
    absx_c = dx_c[CW] ? (CW+1)'(-dx_c) : (CW+1)'(dx_c);
    absy_c = dy_c[CW] ? (CW+1)'(-dy_c) : (CW+1)'(dy_c);
    ax64_c = 64'(absx_c);
    ay64_c = 64'(absy_c);
    adx_c  = (ax64_c > 64'(DIFF_CAP)) ? MW'(DIFF_CAP) : MW'(ax64_c);
    ady_c  = (ay64_c > 64'(DIFF_CAP)) ? MW'(DIFF_CAP) : MW'(ay64_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx1 <= dx_c[CW];
      negy1 <= dy_c[CW];
      adx1  <= adx_c;
      ady1  <= ady_c;
    end
  end

  // Stage 2: squares
  logic            v2, negx2, negy2;
  logic [MW-1:0]   adx2, ady2;
  logic [2*MW-1:0] px2, py2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx2 <= negx1;
      negy2 <= negy1;
      adx2  <= adx1;
      ady2  <= ady1;
      px2   <= adx1 * adx1;
      py2   <= ady1 * ady1;
    end
  end

  // Stage 3: sum of squares
  logic           v3, negx3, negy3, zero3;
  logic [MW-1:0]  adx3, ady3;
  logic [SQW-1:0] sq3;
  logic [SQW-1:0] sq_c;

  assign sq_c = SQW'(px2) + SQW'(py2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negx3 <= negx2;
      negy3 <= negy2;
      adx3  <= adx2;
      ady3  <= ady2;
      sq3   <= sq_c;
      zero3 <= (sq_c == '0);
    end
  end

  // Square root: one result bit per stage
  logic            rt_v    [0:RW];
  logic            rt_negx [0:RW];
  logic            rt_negy [0:RW];
  logic            rt_zero [0:RW];
  logic [MW-1:0]   rt_adx  [0:RW];
  logic [MW-1:0]   rt_ady  [0:RW];
  logic [REMW-1:0] rt_rem  [0:RW];
  logic [RW-1:0]   rt_root [0:RW];
  logic [RADW-1:0] rt_rad  [0:RW];

  assign rt_v[0]    = v3;
  assign rt_negx[0] = negx3;
  assign rt_negy[0] = negy3;
  assign rt_zero[0] = zero3;
  assign rt_adx[0]  = adx3;
  assign rt_ady[0]  = ady3;
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_rad[0]  = RADW'(sq3);

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, trial;
    logic            ge;

    always_comb begin
      rem_sh = {rt_rem[k][REMW-3:0], rt_rad[k][RADW-1:RADW-2]};
      trial  = {rt_root[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[k+1] <= 1'b0;
      end else if (en) begin
        rt_v[k+1] <= rt_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_negx[k+1] <= rt_negx[k];
        rt_negy[k+1] <= rt_negy[k];
        rt_zero[k+1] <= rt_zero[k];
        rt_adx[k+1]  <= rt_adx[k];
        rt_ady[k+1]  <= rt_ady[k];
        rt_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        rt_root[k+1] <= {rt_root[k][RW-2:0], ge};
        rt_rad[k+1]  <= rt_rad[k] << 2;
      end
    end
  end

  // Stage A: stretch
  logic                  va, a_negx, a_negy, a_zero, a_pull;
  logic [MW-1:0]         a_adx, a_ady;
  logic [RW-1:0]         a_len, a_ast;
  logic signed [OUT_W-1:0] a_stretch;
  logic signed [STW-1:0] st_c;
  logic signed [63:0]    st64_c;

  always_comb begin
    st_c   = $signed({1'b0, rt_root[RW]}) - $signed(STW'(rest_length));
    st64_c = 64'(st_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= rt_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_negx <= rt_negx[RW];
      a_negy <= rt_negy[RW];
      a_zero <= rt_zero[RW];
      a_adx  <= rt_adx[RW];
      a_ady  <= rt_ady[RW];
      a_len  <= rt_root[RW];
      a_pull <= (st64_c > 64'sd0);
      a_ast  <= st_c[STW-1] ? RW'(-st_c) : RW'(st_c);
      if (st64_c > OUT_MAX) begin
        a_stretch <= OUT_W'(OUT_MAX);
      end else if (st64_c < OUT_MIN) begin
        a_stretch <= OUT_W'(OUT_MIN);
      end else begin
        a_stretch <= OUT_W'(st64_c);
      end
    end
  end

  // Stage B: stiffness times stretch
  logic                    vb, b_negx, b_negy, b_zero, b_pull;
  logic [MW-1:0]           b_adx, b_ady;
  logic [RW-1:0]           b_len;
  logic signed [OUT_W-1:0] b_stretch;
  logic [KPW-1:0]          b_kprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_negx    <= a_negx;
      b_negy    <= a_negy;
      b_zero    <= a_zero;
      b_pull    <= a_pull;
      b_adx     <= a_adx;
      b_ady     <= a_ady;
      b_len     <= a_len;
      b_stretch <= a_stretch;
      b_kprod   <= KPW'(stiffness) * KPW'(a_ast);
    end
  end

  // Stage C: round and clamp to the force limit
  logic                    vc, c_negx, c_negy, c_zero, c_pull;
  logic [MW-1:0]           c_adx, c_ady;
  logic [RW-1:0]           c_len;
  logic signed [OUT_W-1:0] c_stretch;
  logic [LIMIT_W-1:0]      c_mag;
  logic [KPW:0]            kround_c;
  logic [RNW:0]            mag_c;

  always_comb begin
    kround_c = (KPW+1)'(b_kprod) + (KPW+1)'(1 << (MAG_SHIFT - 1));
    mag_c    = kround_c[KPW:MAG_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_negx    <= b_negx;
      c_negy    <= b_negy;
      c_zero    <= b_zero;
      c_pull    <= b_pull;
      c_adx     <= b_adx;
      c_ady     <= b_ady;
      c_len     <= b_len;
      c_stretch <= b_stretch;
      c_mag     <= (mag_c > (RNW+1)'(force_limit)) ? force_limit : LIMIT_W'(mag_c);
    end
  end

  // Stage D: magnitude times component
  logic                    vd, d_zero, d_sgnx, d_sgny;
  logic [RW-1:0]           d_len;
  logic signed [OUT_W-1:0] d_stretch;
  logic [MPW-1:0]          d_mx, d_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_zero    <= c_zero;
      d_sgnx    <= c_pull != c_negx;
      d_sgny    <= c_pull != c_negy;
      d_len     <= c_len;
      d_stretch <= c_stretch;
      d_mx      <= MPW'(c_mag) * MPW'(c_adx);
      d_my      <= MPW'(c_mag) * MPW'(c_ady);
    end
  end

  // Stage E: numerators and denominator
  logic                    ve, e_zero, e_sgnx, e_sgny;
  logic signed [OUT_W-1:0] e_stretch;
  logic [NW-1:0]           e_numx, e_numy;
  logic [DW-1:0]           e_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_zero    <= d_zero;
      e_sgnx    <= d_sgnx;
      e_sgny    <= d_sgny;
      e_stretch <= d_stretch;
      e_numx    <= {d_mx, 1'b0} + NW'(d_len);
      e_numy    <= {d_my, 1'b0} + NW'(d_len);
      e_den     <= {d_len, 1'b0};
    end
  end

  // Divider: one quotient bit per stage, most significant first
  logic                    dv_v   [0:QUOT_W];
  logic                    dv_zero[0:QUOT_W];
  logic                    dv_sgnx[0:QUOT_W];
  logic                    dv_sgny[0:QUOT_W];
  logic signed [OUT_W-1:0] dv_st  [0:QUOT_W];
  logic [NW-1:0]           dv_rx  [0:QUOT_W];
  logic [NW-1:0]           dv_ry  [0:QUOT_W];
  logic [DW-1:0]           dv_den [0:QUOT_W];
  logic [QUOT_W-1:0]       dv_qx  [0:QUOT_W];
  logic [QUOT_W-1:0]       dv_qy  [0:QUOT_W];

  assign dv_v[0]    = ve;
  assign dv_zero[0] = e_zero;
  assign dv_sgnx[0] = e_sgnx;
  assign dv_sgny[0] = e_sgny;
  assign dv_st[0]   = e_stretch;
  assign dv_rx[0]   = e_numx;
  assign dv_ry[0]   = e_numy;
  assign dv_den[0]  = e_den;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;

  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    localparam int B = QUOT_W - 1 - j;
    logic [NW-1:0] dsh;
    logic          gex, gey;
    logic [QUOT_W-1:0] qx_n, qy_n;

    always_comb begin
      dsh  = NW'(dv_den[j]) << B;
      gex  = (dv_rx[j] >= dsh);
      gey  = (dv_ry[j] >= dsh);
      qx_n = dv_qx[j];
      qy_n = dv_qy[j];
      qx_n[B] = gex;
      qy_n[B] = gey;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_zero[j+1] <= dv_zero[j];
        dv_sgnx[j+1] <= dv_sgnx[j];
        dv_sgny[j+1] <= dv_sgny[j];
        dv_st[j+1]   <= dv_st[j];
        dv_den[j+1]  <= dv_den[j];
        dv_rx[j+1]   <= gex ? dv_rx[j] - dsh : dv_rx[j];
        dv_ry[j+1]   <= gey ? dv_ry[j] - dsh : dv_ry[j];
        dv_qx[j+1]   <= qx_n;
        dv_qy[j+1]   <= qy_n;
      end
    end
  end

  // Output: sign, saturate, hold while stalled
  function automatic logic signed [OUT_W-1:0] sign_sat(input logic [QUOT_W-1:0] q,
                                                       input logic neg);
    logic signed [QUOT_W+1:0] v;
    v = $signed({2'b00, q});
    if (neg) begin
      v = -v;
    end
    if (64'(v) > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end else if (64'(v) < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return OUT_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stretch    <= dv_st[QUOT_W];
      coincident <= dv_zero[QUOT_W];
      force_x    <= dv_zero[QUOT_W] ? '0 : sign_sat(dv_qx[QUOT_W], dv_sgnx[QUOT_W]);
      force_y    <= dv_zero[QUOT_W] ? '0 : sign_sat(dv_qy[QUOT_W], dv_sgny[QUOT_W]);
    end
  end

`ifndef SYNTH
  a_coincident_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coincident |-> force_x == '0 && force_y == '0)
    else $error("coincident result carries nonzero force");

  a_mag_limited: assert property (@(posedge clk) disable iff (rst)
    vc |-> c_mag <= force_limit)
    else $error("force magnitude above limit");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    va && !a_zero |-> a_len != '0)
    else $error("nonzero separation gave zero length");

  a_stall_holds_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(dv_v[QUOT_W]) && $stable(dv_qx[QUOT_W]))
    else $error("divider output moved during stall");
`endif

endmodule
